### hdl/kds_pkg.sv
// shared constants, codes and types of the keyed deadline scheduler
package kds_pkg;

   localparam int TASK_SLOTS_DEF = 16;
   localparam int KEY_BITS_DEF   = 8;
   localparam int TIME_W         = 48;
   localparam int ID_W           = 8;
   localparam int DELAY_W        = 32;
   localparam int OP_W           = 2;
   localparam int STATUS_W       = 3;
   localparam int COUNT_W        = 5;

   typedef enum logic [OP_W-1:0] {
      OP_SCHEDULE = 2'd0,
      OP_CANCEL   = 2'd1,
      OP_TICK     = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_SCHEDULED   = 3'd0,
      ST_FULL        = 3'd1,
      ST_CANCELLED   = 3'd2,
      ST_NOT_FOUND   = 3'd3,
      ST_FIRED       = 3'd4,
      ST_NOTHING_DUE = 3'd5,
      ST_CLEARED     = 3'd6
   } status_type;

   typedef struct packed {
      logic   clear;
      logic   sample;
      logic   slot_valid;
      op_type op;
   } scan_ctl_type;

endpackage

### hdl/kds_if.sv
// request and response channel interfaces
interface kds_req_if import kds_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           operation;
   logic [ID_W-1:0]           context_id;
   logic [ID_W-1:0]           name_id;
   logic signed [DELAY_W-1:0] delay_ms;

   modport source (output valid, output operation, output context_id, output name_id,
                   output delay_ms, input ready);
   modport sink (input valid, input operation, input context_id, input name_id,
                 input delay_ms, output ready);
endinterface

interface kds_rsp_if import kds_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     fired_context;
   logic [ID_W-1:0]     fired_name;
   logic [COUNT_W-1:0]  removed_count;
   logic                last;

   modport source (output valid, output status, output fired_context, output fired_name,
                   output removed_count, output last, input ready);
   modport sink (input valid, input status, input fired_context, input fired_name,
                 input removed_count, input last, output ready);
endinterface

### hdl/kds_ram.sv
// generic single write port ram with registered read
module kds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/kds_scan.sv
// shared compare unit and accumulators for one pass over the task slots
module kds_scan import kds_pkg::*; #(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF,
   parameter int KEY_W      = ID_W,
   localparam int IDX_W  = $clog2(TASK_SLOTS),
   localparam int CNT_W  = $clog2(TASK_SLOTS + 1),
   localparam int WORD_W = 2 * KEY_W + 2 * TIME_W
) (
   input  logic              clock,
   input  logic              reset,
   input  scan_ctl_type      ctl,
   input  logic [IDX_W-1:0]  slot_idx,
   input  logic [WORD_W-1:0] slot_word,
   input  logic [KEY_W-1:0]  key_ctx,
   input  logic [KEY_W-1:0]  key_name,
   input  logic [TIME_W-1:0] now,
   output logic              clear_hit,
   output logic              match_found,
   output logic [IDX_W-1:0]  match_idx,
   output logic              free_found,
   output logic [IDX_W-1:0]  free_idx,
   output logic [IDX_W-1:0]  best_idx,
   output logic [KEY_W-1:0]  best_ctx,
   output logic [KEY_W-1:0]  best_name,
   output logic [CNT_W-1:0]  due_cnt,
   output logic [CNT_W-1:0]  hit_cnt
);

   logic [KEY_W-1:0]  s_ctx;
   logic [KEY_W-1:0]  s_name;
   logic [TIME_W-1:0] s_deadline;
   logic [TIME_W-1:0] s_order;
   logic              ctx_hit, key_hit, due, earlier, take;

   logic              match_found_ff, match_found_in;
   logic              free_found_ff, free_found_in;
   logic              best_found_ff, best_found_in;
   logic [CNT_W-1:0]  due_cnt_ff, due_cnt_in;
   logic [CNT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [KEY_W-1:0]  best_ctx_ff, best_ctx_in;
   logic [KEY_W-1:0]  best_name_ff, best_name_in;
   logic [TIME_W-1:0] best_dl_ff, best_dl_in;
   logic [TIME_W-1:0] best_ord_ff, best_ord_in;

   assign s_ctx      = slot_word[WORD_W-1 -: KEY_W];
   assign s_name     = slot_word[2*TIME_W+KEY_W-1 -: KEY_W];
   assign s_deadline = slot_word[2*TIME_W-1 -: TIME_W];
   assign s_order    = slot_word[TIME_W-1:0];

   assign ctx_hit   = ctl.slot_valid && (s_ctx == key_ctx);
   assign key_hit   = ctx_hit && (s_name == key_name);
   assign due       = ctl.slot_valid && (s_deadline <= now);
   assign earlier   = {s_deadline, s_order} < {best_dl_ff, best_ord_ff};
   assign take      = due && (!best_found_ff || earlier);
   assign clear_hit = ctl.sample && ctx_hit && (ctl.op == OP_CLEAR);

   always_comb begin
      match_found_in = match_found_ff;
      free_found_in  = free_found_ff;
      best_found_in  = best_found_ff;
      due_cnt_in     = due_cnt_ff;
      hit_cnt_in     = hit_cnt_ff;
      match_idx_in   = match_idx_ff;
      free_idx_in    = free_idx_ff;
      best_idx_in    = best_idx_ff;
      best_ctx_in    = best_ctx_ff;
      best_name_in   = best_name_ff;
      best_dl_in     = best_dl_ff;
      best_ord_in    = best_ord_ff;
      if (ctl.clear) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         best_found_in  = 1'b0;
         due_cnt_in     = '0;
         hit_cnt_in     = '0;
      end else if (ctl.sample) begin
         if (key_hit && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = slot_idx;
         end
         if (!ctl.slot_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = slot_idx;
         end
         if (ctx_hit) begin
            hit_cnt_in = hit_cnt_ff + CNT_W'(1);
         end
         if (due) begin
            due_cnt_in = due_cnt_ff + CNT_W'(1);
         end
         if (take) begin
            best_found_in = 1'b1;
            best_idx_in   = slot_idx;
            best_ctx_in   = s_ctx;
            best_name_in  = s_name;
            best_dl_in    = s_deadline;
            best_ord_in   = s_order;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         best_found_ff  <= 1'b0;
         due_cnt_ff     <= '0;
         hit_cnt_ff     <= '0;
      end else begin
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         best_found_ff  <= best_found_in;
         due_cnt_ff     <= due_cnt_in;
         hit_cnt_ff     <= hit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      best_idx_ff  <= best_idx_in;
      best_ctx_ff  <= best_ctx_in;
      best_name_ff <= best_name_in;
      best_dl_ff   <= best_dl_in;
      best_ord_ff  <= best_ord_in;
   end

   assign match_found = match_found_ff;
   assign match_idx   = match_idx_ff;
   assign free_found  = free_found_ff;
   assign free_idx    = free_idx_ff;
   assign best_idx    = best_idx_ff;
   assign best_ctx    = best_ctx_ff;
   assign best_name   = best_name_ff;
   assign due_cnt     = due_cnt_ff;
   assign hit_cnt     = hit_cnt_ff;

endmodule

### hdl/keyed_deadline_scheduler_core.sv
// keyed deadline scheduler: task table, scan sequencer and response register
//
// req carries one operation per transfer: schedule, cancel, a one millisecond tick
// or clear of a context. rsp returns one result per schedule, cancel and clear, and
// for a tick one result per due task in deadline then insertion order, or a single
// nothing due result; last marks the final result of each request.
// Task entries sit in a ram that one compare unit walks one slot per cycle; every
// pass goes through address issue, registered read and decision.
// A schedule, cancel or clear result comes from a single pass; a tick that fires k
// tasks takes k passes. req.ready is high only while no request is in work, so a
// new request is taken only once the last result of the one before is registered.
// rsp is a register: the next request is taken while a result still waits, and a
// stalled receiver only holds the sequencer at its decision step.
// Reset empties the table and zeroes time and insertion order; no ram sweep is
// needed since valid bits guard every entry.
module keyed_deadline_scheduler_core import kds_pkg::*; #(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   kds_req_if.sink   req,
   kds_rsp_if.source rsp
);

   localparam int KEY_W  = (KEY_BITS < ID_W) ? KEY_BITS : ID_W;
   localparam int IDX_W  = $clog2(TASK_SLOTS);
   localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
   localparam int WORD_W = 2 * KEY_W + 2 * TIME_W;
   localparam int DLY_W  = DELAY_W - 1;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_DECIDE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W:0]    addr_ff, addr_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] order_ff, order_in;
   op_type            op_ff, op_in;
   logic [KEY_W-1:0]  ctx_ff, ctx_in;
   logic [KEY_W-1:0]  name_ff, name_in;
   logic [DLY_W-1:0]  delay_ff, delay_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [ID_W-1:0]    fctx_ff, fctx_in;
   logic [ID_W-1:0]    fname_ff, fname_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               last_ff, last_in;

   logic              accept, out_free, scan_clear;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [WORD_W-1:0] wr_word, rd_word;
   scan_ctl_type      scan_ctl;

   logic              clear_hit, match_found, free_found;
   logic [IDX_W-1:0]  match_idx, free_idx, best_idx;
   logic [KEY_W-1:0]  best_ctx, best_name;
   logic [CNT_W-1:0]  due_cnt, hit_cnt;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign wr_word = {ctx_ff, name_ff, now_ff + TIME_W'(delay_ff), order_ff + TIME_W'(1)};

   assign scan_ctl.clear      = scan_clear;
   assign scan_ctl.sample     = pend_ff;
   assign scan_ctl.slot_valid = valid_ff[pend_idx_ff];
   assign scan_ctl.op         = op_ff;

   kds_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TASK_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_word),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   kds_scan #(
      .TASK_SLOTS (TASK_SLOTS),
      .KEY_W      (KEY_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .slot_idx    (pend_idx_ff),
      .slot_word   (rd_word),
      .key_ctx     (ctx_ff),
      .key_name    (name_ff),
      .now         (now_ff),
      .clear_hit   (clear_hit),
      .match_found (match_found),
      .match_idx   (match_idx),
      .free_found  (free_found),
      .free_idx    (free_idx),
      .best_idx    (best_idx),
      .best_ctx    (best_ctx),
      .best_name   (best_name),
      .due_cnt     (due_cnt),
      .hit_cnt     (hit_cnt)
   );

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      pend_in      = 1'b0;
      pend_idx_in  = addr_ff[IDX_W-1:0];
      valid_in     = valid_ff;
      now_in       = now_ff;
      order_in     = order_ff;
      op_in        = op_ff;
      ctx_in       = ctx_ff;
      name_in      = name_ff;
      delay_in     = delay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      fctx_in      = fctx_ff;
      fname_in     = fname_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      scan_clear   = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = free_idx;

      // clear context drops matching slots as the scan passes them
      if (pend_ff && clear_hit) begin
         valid_in[pend_idx_ff] = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req.operation);
               ctx_in   = req.context_id[KEY_W-1:0];
               name_in  = req.name_id[KEY_W-1:0];
               delay_in = req.delay_ms[DELAY_W-1] ? '0 : req.delay_ms[DLY_W-1:0];
               if (op_type'(req.operation) == OP_TICK) begin
                  now_in = now_ff + TIME_W'(1);
               end
               addr_in    = '0;
               scan_clear = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            pend_in     = 1'b1;
            pend_idx_in = addr_ff[IDX_W-1:0];
            addr_in     = addr_ff + (IDX_W + 1)'(1);
            if (addr_ff == (IDX_W + 1)'(TASK_SLOTS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b1;
               count_in     = '0;
               fctx_in      = ID_W'(ctx_ff);
               fname_in     = ID_W'(name_ff);
               state_in     = S_IDLE;
               case (op_ff)
                  OP_SCHEDULE: begin
                     if (match_found || free_found) begin
                        wr_en            = 1'b1;
                        wr_idx           = match_found ? match_idx : free_idx;
                        valid_in[wr_idx] = 1'b1;
                        order_in         = order_ff + TIME_W'(1);
                        status_in        = ST_SCHEDULED;
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  OP_CANCEL: begin
                     if (match_found) begin
                        valid_in[match_idx] = 1'b0;
                        status_in           = ST_CANCELLED;
                     end else begin
                        status_in = ST_NOT_FOUND;
                     end
                  end
                  OP_CLEAR: begin
                     status_in = ST_CLEARED;
                     fname_in  = '0;
                     count_in  = COUNT_W'(hit_cnt);
                  end
                  default: begin
                     if (due_cnt == '0) begin
                        status_in = ST_NOTHING_DUE;
                        fctx_in   = '0;
                        fname_in  = '0;
                     end else begin
                        status_in          = ST_FIRED;
                        fctx_in            = ID_W'(best_ctx);
                        fname_in           = ID_W'(best_name);
                        valid_in[best_idx] = 1'b0;
                        if (due_cnt != CNT_W'(1)) begin
                           // more due tasks remain: rescan for the next one
                           last_in    = 1'b0;
                           addr_in    = '0;
                           scan_clear = 1'b1;
                           state_in   = S_SCAN;
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         now_ff       <= '0;
         order_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         now_ff       <= now_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      op_ff       <= op_in;
      ctx_ff      <= ctx_in;
      name_ff     <= name_in;
      delay_ff    <= delay_in;
      status_ff   <= status_in;
      fctx_ff     <= fctx_in;
      fname_ff    <= fname_in;
      count_ff    <= count_in;
      last_ff     <= last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.fired_context = fctx_ff;
   assign rsp.fired_name    = fname_ff;
   assign rsp.removed_count = count_ff;
   assign rsp.last          = last_ff;

endmodule

### tb/kds_tb_pkg.sv
// result type and task table checker for the keyed deadline scheduler testbench
package kds_tb_pkg;
   import kds_pkg::*;

   typedef struct {
      status_type         status;
      logic [ID_W-1:0]    context_id;
      logic [ID_W-1:0]    name_id;
      logic [COUNT_W-1:0] count;
      logic               last;
   } task_result_type;

   class task_table_checker;
      bit                  slot_busy [TASK_SLOTS_DEF];
      logic [ID_W-1:0]     slot_ctx  [TASK_SLOTS_DEF];
      logic [ID_W-1:0]     slot_nm   [TASK_SLOTS_DEF];
      logic [TIME_W-1:0]   slot_due  [TASK_SLOTS_DEF];
      logic [TIME_W-1:0]   slot_seq  [TASK_SLOTS_DEF];
      logic [TIME_W-1:0]   now_ms;
      logic [TIME_W-1:0]   seq_count;
      task_result_type     awaited_results [$];
      int                  errors;

      function new();
         foreach (slot_busy[i]) slot_busy[i] = 0;
         now_ms    = '0;
         seq_count = '0;
         errors    = 0;
      endfunction

      function void append_result(task_result_type r);
         awaited_results.insert(awaited_results.size(), r);
      endfunction

      function void push_result(status_type st, logic [ID_W-1:0] ctx, logic [ID_W-1:0] nm,
                                logic [COUNT_W-1:0] cnt, logic last);
         task_result_type r;
         r = '{status: st, context_id: ctx, name_id: nm, count: cnt, last: last};
         append_result(r);
      endfunction

      function int find_key(logic [ID_W-1:0] ctx, logic [ID_W-1:0] nm);
         for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
            if (slot_busy[i] && slot_ctx[i] == ctx && slot_nm[i] == nm) return i;
         end
         return -1;
      endfunction

      // works out the results of one accepted request and updates the table
      function void apply_request(op_type op, logic [ID_W-1:0] ctx, logic [ID_W-1:0] nm,
                                  logic signed [DELAY_W-1:0] delay);
         int                s;
         int                best;
         int                fired;
         int                cnt;
         logic [TIME_W-1:0] wait_ms;
         task_result_type   r;
         case (op)
            OP_SCHEDULE: begin
               wait_ms = delay[DELAY_W-1] ? '0 : {{(TIME_W-DELAY_W){1'b0}}, delay};
               s = find_key(ctx, nm);
               if (s < 0) begin
                  for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
                     if (!slot_busy[i]) begin
                        s = i;
                        break;
                     end
                  end
               end
               if (s < 0) begin
                  push_result(ST_FULL, ctx, nm, '0, 1'b1);
               end else begin
                  seq_count    = seq_count + 1'b1;
                  slot_busy[s] = 1'b1;
                  slot_ctx[s]  = ctx;
                  slot_nm[s]   = nm;
                  slot_due[s]  = now_ms + wait_ms;
                  slot_seq[s]  = seq_count;
                  push_result(ST_SCHEDULED, ctx, nm, '0, 1'b1);
               end
            end
            OP_CANCEL: begin
               s = find_key(ctx, nm);
               if (s < 0) begin
                  push_result(ST_NOT_FOUND, ctx, nm, '0, 1'b1);
               end else begin
                  slot_busy[s] = 1'b0;
                  push_result(ST_CANCELLED, ctx, nm, '0, 1'b1);
               end
            end
            OP_CLEAR: begin
               cnt = 0;
               for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
                  if (slot_busy[i] && slot_ctx[i] == ctx) begin
                     slot_busy[i] = 1'b0;
                     cnt++;
                  end
               end
               push_result(ST_CLEARED, ctx, '0, COUNT_W'(cnt), 1'b1);
            end
            default: begin
               now_ms = now_ms + 1'b1;
               fired  = 0;
               while (1) begin
                  best = -1;
                  for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
                     if (slot_busy[i] && slot_due[i] <= now_ms) begin
                        if (best < 0 || slot_due[i] < slot_due[best] ||
                            (slot_due[i] == slot_due[best] && slot_seq[i] < slot_seq[best]))
                           best = i;
                     end
                  end
                  if (best < 0) break;
                  slot_busy[best] = 1'b0;
                  push_result(ST_FIRED, slot_ctx[best], slot_nm[best], '0, 1'b0);
                  fired++;
               end
               if (fired == 0) begin
                  push_result(ST_NOTHING_DUE, '0, '0, '0, 1'b1);
               end else begin
                  r = awaited_results.pop_back();
                  r.last = 1'b1;
                  append_result(r);
               end
            end
         endcase
      endfunction

      function void compare_field(string label, int unsigned want, int unsigned got,
                                  longint stamp);
         if (want != got) begin
            errors++;
            $display("%0d ns: %s mismatch, expected %0d, actual %0d",
                     stamp, label, want, got);
         end
      endfunction

      // checks one accepted result against the oldest awaited one
      function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] ctx,
                                 logic [ID_W-1:0] nm, logic [COUNT_W-1:0] cnt,
                                 logic last, longint stamp);
         task_result_type want;
         if (awaited_results.size() == 0) begin
            errors++;
            $display("%0d ns: unexpected result, expected none, actual status %0d key %0d/%0d",
                     stamp, status, ctx, nm);
            return;
         end
         want = awaited_results.pop_front();
         compare_field("status", int'(want.status), status, stamp);
         compare_field("fired_context", want.context_id, ctx, stamp);
         compare_field("fired_name", want.name_id, nm, stamp);
         compare_field("removed_count", want.count, cnt, stamp);
         compare_field("last", want.last, last, stamp);
      endfunction
   endclass

endpackage

### tb/tb_top.sv
// top level testbench of the keyed deadline scheduler core
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kds_pkg::*;
   import kds_tb_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int TAIL_CYCLES = 2 * TASK_SLOTS_DEF + 10;

   logic              clock;
   logic              reset;
   bit                calm_req;
   bit                calm_rsp;
   int                idle_cycles;
   task_table_checker board;

   kds_req_if req_ch ();
   kds_rsp_if rsp_ch ();

   keyed_deadline_scheduler_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // no transfer on either side for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   task automatic send_request(op_type op, logic [ID_W-1:0] ctx, logic [ID_W-1:0] nm,
                               logic signed [DELAY_W-1:0] delay);
      int gap;
      gap = calm_req ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.operation  = op;
      req_ch.context_id = ctx;
      req_ch.name_id    = nm;
      req_ch.delay_ms   = delay;
      req_ch.valid      = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      board.apply_request(op, ctx, nm, delay);
      @(negedge clock);
   endtask

   function automatic logic signed [DELAY_W-1:0] draw_delay();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return -$signed(DELAY_W'($urandom_range(1, 1000)));
         2:       return $urandom;
         3:       return {1'b0, 31'($urandom)};
         default: return $urandom_range(0, 12);
      endcase
   endfunction

   task automatic send_random(int sched_pct);
      int               r;
      logic [ID_W-1:0]  ctx;
      logic [ID_W-1:0]  nm;
      op_type           op;
      ctx = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, 255))
                                        : ID_W'($urandom_range(0, 3));
      nm  = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, 255))
                                        : ID_W'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      if (r < sched_pct) begin
         op = OP_SCHEDULE;
      end else begin
         r = $urandom_range(0, 9);
         op = (r < 5) ? OP_TICK : (r < 8) ? OP_CANCEL : OP_CLEAR;
      end
      send_request(op, ctx, nm, draw_delay());
   endtask

   // result side with random stalls
   initial begin
      rsp_ch.ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         int stall;
         stall = calm_rsp ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         board.check_result(rsp_ch.status, rsp_ch.fired_context, rsp_ch.fired_name,
                            rsp_ch.removed_count, rsp_ch.last, $time);
         @(negedge clock);
      end
   end

   initial begin
      int                         pcts [3];
      logic signed [DELAY_W-1:0]  dly;
      board             = new();
      pcts              = '{25, 50, 75};
      calm_req          = 1'b0;
      calm_rsp          = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.operation  = OP_SCHEDULE;
      req_ch.context_id = '0;
      req_ch.name_id    = '0;
      req_ch.delay_ms   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table cases
      send_request(OP_TICK, '0, '0, '0);
      send_request(OP_CANCEL, 8'hFF, 8'hFF, '0);
      send_request(OP_CLEAR, 8'h00, '0, '0);
      // fill every slot with clamped, short and far deadlines
      for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
         case (i % 4)
            0:       dly = 32'sh8000_0000;
            1:       dly = 2;
            2:       dly = 32'sh7FFF_FFFF;
            default: dly = -1;
         endcase
         send_request(OP_SCHEDULE, (i < 8) ? 8'h01 : 8'hFF, ID_W'(i * 17), dly);
      end
      send_request(OP_SCHEDULE, 8'h00, 8'h00, 3);
      // replace a pending key while the table is full
      send_request(OP_SCHEDULE, 8'h01, 8'd34, 1);
      send_request(OP_CANCEL, 8'h01, 8'd51, '0);
      // ties on deadline resolve by insertion order
      send_request(OP_TICK, '0, '0, '0);
      send_request(OP_TICK, '0, '0, '0);
      send_request(OP_CLEAR, 8'hFF, '0, '0);

      for (int phase = 0; phase < 9; phase++) begin
         calm_req = ($urandom_range(0, 3) == 0);
         calm_rsp = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 48; n++) send_random(pcts[$urandom_range(0, 2)] +
                                                  ((phase % 3 == 0) ? 20 : 0));
      end
      req_ch.valid = 1'b0;

      while (board.awaited_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.awaited_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/kds_pkg.sv
hdl/kds_if.sv
hdl/kds_ram.sv
hdl/kds_scan.sv
hdl/keyed_deadline_scheduler_core.sv
tb/kds_tb_pkg.sv
tb/tb_top.sv
